@@ rtl/core/facrr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// facrr_pkg
// Shared constants, types and helpers for the fully associative tag cache.
// ============================================================================
package facrr_pkg;

    // Cache geometry
    localparam int CACHE_BYTES   = 32768;
    localparam int ADDRESS_BITS  = 26;
    localparam int MIN_LINE_LOG2 = 3;
    localparam int MAX_LINE_LOG2 = 6;
    localparam int SLOT_CAP      = CACHE_BYTES >> MIN_LINE_LOG2;
    localparam int SLOT_W        = $clog2(SLOT_CAP);
    localparam int COUNT_W       = SLOT_W + 1;
    localparam int TAG_W         = ADDRESS_BITS - MIN_LINE_LOG2;
    localparam int RND_W         = 16;

    // Cell chain: slot = {row, cell}
    localparam int N_CELLS   = 16;
    localparam int CELL_W    = $clog2(N_CELLS);
    localparam int ROWS      = SLOT_CAP / N_CELLS;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ROW_CNT_W = ROW_W + 1;

    // Line size register
    localparam int SHIFT_W = $clog2(MAX_LINE_LOG2 - MIN_LINE_LOG2 + 1);
    localparam int LINE_W  = 3;
    localparam logic [LINE_W-1:0] LINE_RESET = LINE_W'(MIN_LINE_LOG2);

    // APB register map
    localparam int DATA_W     = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_LINE_CFG = 1'b0;  // register index taken from paddr[2]

    // Search token passed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
    } token_t;

    // Tag write broadcast to the cells
    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [CELL_W-1:0] bank;
        logic [TAG_W-1:0]  tag;
    } wr_t;

    // Clamp the line size to its legal range, return the extra shift above minimum
    function automatic logic [SHIFT_W-1:0] eff_shift(input logic [LINE_W-1:0] line_log2);
        logic [SHIFT_W-1:0] s;
        if (line_log2 < LINE_W'(MIN_LINE_LOG2))
            s = '0;
        else if (line_log2 > LINE_W'(MAX_LINE_LOG2))
            s = SHIFT_W'(MAX_LINE_LOG2 - MIN_LINE_LOG2);
        else
            s = SHIFT_W'(line_log2 - LINE_W'(MIN_LINE_LOG2));
        return s;
    endfunction

endpackage

@@ rtl/core/facrr_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// facrr_cell
// One cell of the search chain: a tag bank, a compare, and a token register.
// ============================================================================
module facrr_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [facrr_pkg::CELL_W-1:0]   cell_idx,
    input  logic [facrr_pkg::TAG_W-1:0]    key,
    input  logic [facrr_pkg::COUNT_W-1:0]  limit,
    input  facrr_pkg::wr_t                 wr,
    input  facrr_pkg::token_t              tok_in,
    output facrr_pkg::token_t              tok_out
);

    logic [facrr_pkg::TAG_W-1:0]  mem [facrr_pkg::ROWS];
    logic [facrr_pkg::TAG_W-1:0]  rdata_reg;
    facrr_pkg::token_t            tok_reg;
    logic [facrr_pkg::SLOT_W-1:0] slot_id;
    logic                         match;

    // Tag bank: one write port, one registered read at the incoming token's row
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.bank == cell_idx))
            mem[wr.row] <= wr.tag;
        rdata_reg <= mem[tok_in.row];
    end

    // Token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_in;
    end

    // Compare; a slot is live only below the filled/slot-count limit
    assign slot_id = {tok_reg.row, cell_idx};
    assign match   = tok_reg.valid && !tok_reg.hit
                     && ({1'b0, slot_id} < limit)
                     && (rdata_reg == key);

    always_comb
    begin
        tok_out = tok_reg;
        if (match)
        begin
            tok_out.hit      = 1'b1;
            tok_out.hit_slot = slot_id;
        end
    end

endmodule

@@ rtl/core/facrr_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// facrr_ctrl
// Access sequencer: latches a request, feeds row tokens into the cell chain,
// collects the first hit, picks and writes a victim on a miss, holds result.
// ============================================================================
module facrr_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [facrr_pkg::LINE_W-1:0]       line_log2,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [facrr_pkg::ADDRESS_BITS-1:0] address,
    input  logic [facrr_pkg::RND_W-1:0]        random_value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [facrr_pkg::SLOT_W-1:0]       slot,
    // chain side
    output logic [facrr_pkg::TAG_W-1:0]        key,
    output logic [facrr_pkg::COUNT_W-1:0]      limit,
    output facrr_pkg::wr_t                     wr,
    output facrr_pkg::token_t                  issue_tok,
    input  facrr_pkg::token_t                  chain_tok
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [facrr_pkg::ROW_CNT_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [facrr_pkg::ROW_CNT_W-1:0]  nrows_reg, nrows_next;
    logic [facrr_pkg::COUNT_W-1:0]    filled_reg, filled_next;
    logic [facrr_pkg::COUNT_W-1:0]    limit_reg, limit_next;
    logic [facrr_pkg::COUNT_W-1:0]    slots_reg, slots_next;
    logic [facrr_pkg::TAG_W-1:0]      key_reg, key_next;
    logic [facrr_pkg::SLOT_W-1:0]     rnd_reg, rnd_next;
    logic                             found_reg, found_next;
    logic [facrr_pkg::SLOT_W-1:0]     found_slot_reg, found_slot_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_hit_reg, out_hit_next;
    logic [facrr_pkg::SLOT_W-1:0]     out_slot_reg, out_slot_next;

    logic [facrr_pkg::SHIFT_W-1:0]    shift;
    logic [facrr_pkg::TAG_W-1:0]      key_calc;
    logic [facrr_pkg::COUNT_W-1:0]    slots_calc;
    logic [facrr_pkg::COUNT_W-1:0]    limit_calc;
    logic [facrr_pkg::ROW_CNT_W-1:0]  nrows_calc;
    logic                             full;
    logic [facrr_pkg::SLOT_W-1:0]     victim;
    logic                             last_row;
    logic                             chain_hit;
    logic                             accept;

    // Request decode: tag, slot count, live limit, rows to scan
    assign shift      = facrr_pkg::eff_shift(line_log2);
    assign key_calc   = facrr_pkg::TAG_W'(address >> facrr_pkg::MIN_LINE_LOG2) >> shift;
    assign slots_calc = facrr_pkg::COUNT_W'(facrr_pkg::SLOT_CAP) >> shift;
    assign limit_calc = (filled_reg < slots_calc) ? filled_reg : slots_calc;
    assign nrows_calc = facrr_pkg::ROW_CNT_W'(
                            (limit_calc + facrr_pkg::COUNT_W'(facrr_pkg::N_CELLS - 1))
                            >> facrr_pkg::CELL_W);

    // Victim: ascending fill until full, then random modulo slot count
    assign full   = (filled_reg >= slots_reg);
    assign victim = full ? (rnd_reg & facrr_pkg::SLOT_W'(slots_reg - 1'b1))
                         : filled_reg[facrr_pkg::SLOT_W-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign last_row  = (row_cnt_reg == (nrows_reg - 1'b1));
    assign chain_hit = chain_tok.valid && chain_tok.hit;

    // Token into the head of the chain
    always_comb
    begin
        issue_tok          = '0;
        issue_tok.valid    = (state_reg == ST_SCAN);
        issue_tok.last     = last_row;
        issue_tok.row      = row_cnt_reg[facrr_pkg::ROW_W-1:0];
    end

    // Victim write broadcast
    always_comb
    begin
        wr.en   = (state_reg == ST_WRITE);
        wr.row  = victim[facrr_pkg::SLOT_W-1 -: facrr_pkg::ROW_W];
        wr.bank = victim[facrr_pkg::CELL_W-1:0];
        wr.tag  = key_reg;
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        row_cnt_next    = row_cnt_reg;
        nrows_next      = nrows_reg;
        filled_next     = filled_reg;
        limit_next      = limit_reg;
        slots_next      = slots_reg;
        key_next        = key_reg;
        rnd_next        = rnd_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        out_slot_next   = out_slot_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // first hit leaving the chain is the lowest matching slot
        if (chain_hit && !found_reg)
        begin
            found_next      = 1'b1;
            found_slot_next = chain_tok.hit_slot;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next     = key_calc;
                    rnd_next     = random_value[facrr_pkg::SLOT_W-1:0];
                    slots_next   = slots_calc;
                    limit_next   = limit_calc;
                    nrows_next   = nrows_calc;
                    row_cnt_next = '0;
                    found_next   = 1'b0;
                    state_next   = (nrows_calc == '0) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                row_cnt_next = row_cnt_reg + 1'b1;
                if (last_row)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (chain_tok.valid && chain_tok.last)
                    state_next = (found_reg || chain_hit) ? ST_RESULT : ST_WRITE;
            end
            ST_WRITE:
            begin
                found_slot_next = victim;
                if (!full)
                    filled_next = filled_reg + 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = found_reg;
                    out_slot_next  = found_slot_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            nrows_reg     <= '0;
            filled_reg    <= '0;
            limit_reg     <= '0;
            slots_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            nrows_reg     <= nrows_next;
            filled_reg    <= filled_next;
            limit_reg     <= limit_next;
            slots_reg     <= slots_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        rnd_reg        <= rnd_next;
        found_slot_reg <= found_slot_next;
        out_hit_reg    <= out_hit_next;
        out_slot_reg   <= out_slot_next;
    end

    assign key       = key_reg;
    assign limit     = limit_reg;
    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign slot      = out_slot_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= facrr_pkg::COUNT_W'(facrr_pkg::SLOT_CAP))
        else $error("fill count above capacity");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (filled_reg != $past(filled_reg)) |-> (filled_reg == $past(filled_reg) + 1'b1))
        else $error("fill count moved by more than one");

    a_no_write_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !found_reg)
        else $error("victim write after a hit");

    a_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> ({1'b0, victim} < slots_reg))
        else $error("victim outside slot count");

    a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_tok.valid |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("token left chain outside a search");

endmodule

@@ rtl/core/fully_assoc_cache_random_repl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fully_assoc_cache_random_repl
// Tag-only fully associative cache with ascending fill and random replacement.
// ============================================================================
// One access at a time. An access scans the rows that hold live slots, where the
// live slots are the smaller of the fill count and the slot count (32768 >> line
// size); a miss then adds a victim write, which a hit skips. An access on an empty
// cache skips the search; the search is longest at 8-byte lines with every slot
// filled. One row of the 16 tag banks enters the cell chain per cycle, and each
// row passes through the token registers of the 16 cells before it leaves.
// The slot valid state is implied by the fill count, so no clearing pass runs
// after reset. The next request is taken while a finished result still waits on
// the output register; its own result then waits until that result transfers.
module fully_assoc_cache_random_repl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [facrr_pkg::ADDRESS_BITS-1:0]    address,
    input  logic [facrr_pkg::RND_W-1:0]           random_value,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic [facrr_pkg::SLOT_W-1:0]          slot,
    // APB configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [facrr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [facrr_pkg::DATA_W-1:0]          pwdata,
    output logic [facrr_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready
);

    logic [facrr_pkg::LINE_W-1:0]  line_log2_reg;
    logic [facrr_pkg::TAG_W-1:0]   key;
    logic [facrr_pkg::COUNT_W-1:0] limit;
    facrr_pkg::wr_t                wr;
    facrr_pkg::token_t             chain [facrr_pkg::N_CELLS+1];

    // Line size register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_log2_reg <= facrr_pkg::LINE_RESET;
        else if (psel && penable && pwrite && (paddr[2] == facrr_pkg::REG_LINE_CFG))
            line_log2_reg <= pwdata[facrr_pkg::LINE_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == facrr_pkg::REG_LINE_CFG)
            prdata = facrr_pkg::DATA_W'(line_log2_reg);
    end

    // Sequencer
    facrr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_log2    (line_log2_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .address      (address),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .slot         (slot),
        .key          (key),
        .limit        (limit),
        .wr           (wr),
        .issue_tok    (chain[0]),
        .chain_tok    (chain[facrr_pkg::N_CELLS])
    );

    // Cell chain
    for (genvar g = 0; g < facrr_pkg::N_CELLS; g++)
    begin : g_cell
        facrr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (facrr_pkg::CELL_W'(g)),
            .key      (key),
            .limit    (limit),
            .wr       (wr),
            .tok_in   (chain[g]),
            .tok_out  (chain[g+1])
        );
    end

endmodule

@@ tb/facrr_tag_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// facrr_tag_checker
// Watches the request, result and APB channels of the tag cache, keeps a
// shadow copy of the tag store and fill state, and compares every result
// transfer field by field with the oldest predicted lookup.
// ============================================================================
module facrr_tag_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [facrr_pkg::ADDRESS_BITS-1:0]    address,
    input  logic [facrr_pkg::RND_W-1:0]           random_value,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic                                  hit,
    input  logic [facrr_pkg::SLOT_W-1:0]          slot,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic                                  pready,
    input  logic [facrr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [facrr_pkg::DATA_W-1:0]          pwdata,
    output int                                    fail_count,
    output int                                    pending
);
    import facrr_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } lookup_t;

    // Shadow cache state
    logic [TAG_W-1:0]  tag_mem [SLOT_CAP];
    bit                slot_used [SLOT_CAP];
    int                fill_cnt;
    logic [LINE_W-1:0] line_reg;

    lookup_t lookup_q [$];
    int      n_fail = 0;

    assign fail_count = n_fail;

    // Clamp the line size register to 8..64 byte lines
    function automatic int line_shift(input logic [LINE_W-1:0] v);
        if (v < MIN_LINE_LOG2)
            return MIN_LINE_LOG2;
        if (v > MAX_LINE_LOG2)
            return MAX_LINE_LOG2;
        return int'(v);
    endfunction

    // Search the active slots; on a miss fill ascending, else evict at random
    function automatic lookup_t predict_access(input logic [ADDRESS_BITS-1:0] addr,
                                               input logic [RND_W-1:0] rnd);
        int               sh;
        int               nslots;
        int               victim;
        logic [TAG_W-1:0] tag;
        lookup_t          res;
        sh     = line_shift(line_reg);
        nslots = CACHE_BYTES >> sh;
        tag    = TAG_W'(addr >> sh);
        res    = '0;
        // lowest matching slot wins when a tag sits in several slots
        for (int i = 0; i < nslots; i++)
        begin
            if (slot_used[i] && tag_mem[i] == tag)
            begin
                res.hit  = 1'b1;
                res.slot = SLOT_W'(i);
                return res;
            end
        end
        if (fill_cnt < nslots)
        begin
            victim   = fill_cnt;
            fill_cnt = fill_cnt + 1;
        end
        else
        begin
            victim = int'(rnd) & (nslots - 1);
        end
        tag_mem[victim]   = tag;
        slot_used[victim] = 1'b1;
        res.slot          = SLOT_W'(victim);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int act_val);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
        n_fail = n_fail + 1;
    endtask

    // Channel monitor: config writes, result compare, request prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_CAP; i++)
                slot_used[i] = 1'b0;
            fill_cnt = 0;
            line_reg = LINE_RESET;
            lookup_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_CFG)
                line_reg = pwdata[LINE_W-1:0];

            if (out_valid && out_ready)
            begin
                if (lookup_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, hit %0d slot %0d",
                             $time, hit, slot);
                    n_fail = n_fail + 1;
                end
                else
                begin
                    lookup_t exp_r;
                    exp_r = lookup_q.pop_front();
                    if (hit !== exp_r.hit)
                        report_mismatch("hit", exp_r.hit, hit);
                    if (slot !== exp_r.slot)
                        report_mismatch("slot", exp_r.slot, slot);
                end
            end

            if (in_valid && in_ready)
                lookup_q.push_back(predict_access(address, random_value));

            pending <= lookup_q.size();
        end
    end

endmodule

@@ tb/fully_assoc_cache_random_repl_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fully_assoc_cache_random_repl_tb
// Drives accesses and line size writes into the tag cache: a directed pass
// over address extremes and clamped line sizes, then random phases that fill
// the cache, run it full under random replacement, and revisit tags across
// line size changes. The checker beside the block scores every result.
// ============================================================================
module fully_assoc_cache_random_repl_tb;
    import facrr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int IDLE_PCT       = 29;
    localparam int POOL_DEPTH     = 64;
    localparam int N_PHASES       = 8;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [ADDRESS_BITS-1:0] address;
    logic [RND_W-1:0]        random_value;
    logic                    out_valid;
    logic                    out_ready;
    logic                    hit;
    logic [SLOT_W-1:0]       slot;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    bit steady = 1'b0;
    int tag_pool [$];

    // Random phases: line size register value, transfers, percent fresh lines
    int phase_line  [N_PHASES] = '{4, 6, 6, 3, 7, 0, 6, 3};
    int phase_items [N_PHASES] = '{60, 380, 60, 30, 20, 15, 20, 10};
    int phase_fresh [N_PHASES] = '{95, 100, 90, 90, 65, 80, 50, 40};

    fully_assoc_cache_random_repl u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .address      (address),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .slot         (slot),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    facrr_tag_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .address      (address),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .slot         (slot),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side backpressure
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // Watchdog: no transfer on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // One request transfer; valid is left high for the caller
    task automatic send_access(input logic [ADDRESS_BITS-1:0] addr,
                               input logic [RND_W-1:0] rnd);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        address      <= addr;
        random_value <= rnd;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending and wait until every predicted lookup has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // APB write of the line size register, setup then access
    task automatic write_line(input int v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LINE_CFG, 2'b00};
        pwdata  <= ($urandom & ~32'h7) | DATA_W'(v & 7);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reconfigure(input int v);
        drain();
        write_line(v);
    endtask

    initial
    begin
        int sh;
        int t;
        int addr;
        in_valid     <= 1'b0;
        address      <= '0;
        random_value <= '0;
        out_ready    <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        rst_n        <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: address extremes, offset hits, random value extremes
        write_line(3);
        send_access(26'h0000000, 16'h0000);
        send_access(26'h0000007, 16'hFFFF);
        send_access(26'h3FFFFFF, 16'hFFFF);
        send_access(26'h3FFFFF8, 16'h1234);
        send_access(26'h0000008, 16'h0000);
        // line size below range clamps to 8 byte lines
        reconfigure(0);
        send_access(26'h0000010, 16'hAAAA);
        send_access(26'h0000000, 16'h5555);
        // above range clamps to 64 byte lines; the tag of address zero stored at 8 bytes still matches
        reconfigure(7);
        send_access(26'h0000000, 16'h0000);
        send_access(26'h3FFFFC0, 16'hFFFF);
        send_access(26'h0000040, 16'h8000);
        reconfigure(2);
        send_access(26'h0000018, 16'h0001);
        send_access(26'h3FFFFFF, 16'h0000);
        reconfigure(1);
        send_access(26'h0000020, 16'hFFFF);
        reconfigure(5);
        send_access(26'h0000000, 16'h0000);

        // Random phases: fill, run full under replacement, revisit across sizes
        for (int p = 0; p < N_PHASES; p++)
        begin
            reconfigure(phase_line[p]);
            sh = (phase_line[p] < MIN_LINE_LOG2) ? MIN_LINE_LOG2 :
                 (phase_line[p] > MAX_LINE_LOG2) ? MAX_LINE_LOG2 : phase_line[p];
            for (int k = 0; k < phase_items[p]; k++)
            begin
                if (p == 1 && k == 40)
                    steady <= 1'b1;
                if (p == 1 && k == 160)
                    steady <= 1'b0;
                if (p == 1 && k == 200)
                    drain();
                if (tag_pool.size() == 0 || $urandom_range(99) < phase_fresh[p])
                begin
                    // fresh line, low addresses often so tags fit any line size
                    if ($urandom_range(2) == 0)
                        addr = $urandom_range((1 << 23) - 1);
                    else
                        addr = $urandom & ((1 << ADDRESS_BITS) - 1);
                end
                else
                begin
                    // same tag under the current line size, random byte offset
                    t    = tag_pool[$urandom_range(tag_pool.size() - 1)];
                    addr = ((t << sh) | ($urandom & ((1 << sh) - 1)))
                           & ((1 << ADDRESS_BITS) - 1);
                end
                tag_pool.push_back(addr >> sh);
                if (tag_pool.size() > POOL_DEPTH)
                    void'(tag_pool.pop_front());
                send_access(ADDRESS_BITS'(addr), RND_W'($urandom));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
